// ===== rtl/cfwd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfwd_pkg
// Opcodes and controller/datapath handshake types of the ring-buffer FIFO.
// ----------------------------------------------------------------------------
package cfwd_pkg;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_DRAIN = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam int unsigned ITEM_W = 32;
	localparam int unsigned FILL_W = 5;

	// commands from controller to datapath
	typedef struct packed {
		logic consume;   // retire the held command
		logic wr;        // store held word at tail
		logic pop;       // advance head, decrement count
		logic clr;       // reset pointers and count
		logic load;      // load the output register
		logic sel_data;  // result carries the ram read word
		logic accepted;  // push stored its word
		logic last;      // final result of this command
	} cfwd_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] op;
		logic       empty;
		logic       full;
		logic       one_left;
		logic       out_free;
	} cfwd_stat_t;

endpackage

// ===== rtl/cfwd_items_if.sv =====
// ----------------------------------------------------------------------------
// cfwd_items_if
// Input channel: opcode and word with valid/ready.
// ----------------------------------------------------------------------------
interface cfwd_items_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic [cfwd_pkg::ITEM_W-1:0]   item_word;

	modport source (output valid, output opcode, output item_word, input ready);
	modport sink   (input valid, input opcode, input item_word, output ready);
endinterface

// ===== rtl/cfwd_results_if.sv =====
// ----------------------------------------------------------------------------
// cfwd_results_if
// Result channel: word, flags and fill count with valid/ready.
// ----------------------------------------------------------------------------
interface cfwd_results_if;
	logic                          valid;
	logic                          ready;
	logic [cfwd_pkg::ITEM_W-1:0]   out_word;
	logic                          out_valid;
	logic                          push_accepted;
	logic                          is_last;
	logic [cfwd_pkg::FILL_W-1:0]   fill_count;

	modport source (output valid, output out_word, output out_valid,
		output push_accepted, output is_last, output fill_count, input ready);
	modport sink   (input valid, input out_word, input out_valid,
		input push_accepted, input is_last, input fill_count, output ready);
endinterface

// ===== rtl/cfwd_ram.sv =====
// ----------------------------------------------------------------------------
// cfwd_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module cfwd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cfwd_datapath.sv =====
// ----------------------------------------------------------------------------
// cfwd_datapath
// Command register, ring pointers, entry ram and output register.
// ----------------------------------------------------------------------------
module cfwd_datapath #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cfwd_items_if.sink            items,
	cfwd_results_if.source        results,
	input  cfwd_pkg::cfwd_ctl_t   ctl,
	output cfwd_pkg::cfwd_stat_t  stat
);
	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = cfwd_pkg::ITEM_W;

	logic             cmd_valid_q;
	logic [1:0]       op_q;
	logic [IW-1:0]    word_q;
	logic [PW-1:0]    head_q, tail_q, head_inc, tail_inc;
	logic [CW-1:0]    count_q, count_d;
	logic [WORD_WIDTH-1:0] wdata, rdata;
	logic [IW-1:0]    rd_word;

	logic             ovalid_q;
	logic [IW-1:0]    oword_q;
	logic             odata_q, oacc_q, olast_q;
	logic [cfwd_pkg::FILL_W-1:0] ofill_q;

	// word width conversion between port and store
	generate
		if (WORD_WIDTH <= IW) begin : g_narrow
			assign wdata   = word_q[WORD_WIDTH-1:0];
			assign rd_word = IW'(rdata);
		end else begin : g_wide
			assign wdata   = WORD_WIDTH'(word_q);
			assign rd_word = rdata[IW-1:0];
		end
	endgenerate

	assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	always_comb begin
		count_d = count_q;
		if (ctl.clr) begin
			count_d = '0;
		end else if (ctl.wr) begin
			count_d = count_q + 1'b1;
		end else if (ctl.pop) begin
			count_d = count_q - 1'b1;
		end
	end

	// held command, one at a time
	assign items.ready = !cmd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (items.valid && items.ready) begin
			cmd_valid_q <= 1'b1;
		end else if (ctl.consume) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_q   <= items.opcode;
			word_q <= items.item_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (ctl.clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (ctl.wr) begin
					tail_q <= tail_inc;
				end
				if (ctl.pop) begin
					head_q <= head_inc;
				end
			end
		end
	end

	// read address looks ahead so consecutive drain reads are back to back
	cfwd_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ctl.wr),
		.waddr (tail_q),
		.wdata (wdata),
		.raddr (ctl.pop ? head_inc : head_q),
		.rdata (rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.load) begin
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			oword_q <= ctl.sel_data ? rd_word : '0;
			odata_q <= ctl.sel_data;
			oacc_q  <= ctl.accepted;
			olast_q <= ctl.last;
			ofill_q <= cfwd_pkg::FILL_W'(count_d);
		end
	end

	assign results.valid         = ovalid_q;
	assign results.out_word      = oword_q;
	assign results.out_valid     = odata_q;
	assign results.push_accepted = oacc_q;
	assign results.is_last       = olast_q;
	assign results.fill_count    = ofill_q;

	always_comb begin
		stat.cmd_valid = cmd_valid_q;
		stat.op        = op_q;
		stat.empty     = (count_q == '0);
		stat.full      = (count_q == CW'(DEPTH));
		stat.one_left  = (count_q == CW'(1));
		stat.out_free  = !ovalid_q || results.ready;
	end
endmodule

// ===== rtl/cfwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfwd_ctrl
// Sequencer: decodes the held command and steps pops and drains.
// ----------------------------------------------------------------------------
module cfwd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfwd_pkg::cfwd_stat_t  stat,
	output cfwd_pkg::cfwd_ctl_t   ctl
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (stat.cmd_valid) begin
					case (stat.op)
						cfwd_pkg::OP_PUSH: begin
							if (stat.out_free) begin
								ctl.consume  = 1'b1;
								ctl.load     = 1'b1;
								ctl.wr       = !stat.full;
								ctl.accepted = !stat.full;
								ctl.last     = 1'b1;
							end
						end
						cfwd_pkg::OP_CLEAR: begin
							if (stat.out_free) begin
								ctl.consume = 1'b1;
								ctl.load    = 1'b1;
								ctl.clr     = 1'b1;
								ctl.last    = 1'b1;
							end
						end
						default: begin
							// pop or drain
							if (!stat.empty) begin
								state_d = S_READ;
							end else if (stat.out_free) begin
								ctl.consume = 1'b1;
								ctl.load    = 1'b1;
								ctl.last    = 1'b1;
							end
						end
					endcase
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					ctl.load     = 1'b1;
					ctl.pop      = 1'b1;
					ctl.sel_data = 1'b1;
					ctl.last     = (stat.op == cfwd_pkg::OP_POP) || stat.one_left;
					if (ctl.last) begin
						ctl.consume = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/circular_fifo_with_drain_unit.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_drain_unit
// Ring-buffer fifo of DEPTH words with push, pop, drain-all and clear.
// ----------------------------------------------------------------------------
// usage
//   items channel: one word per command, opcode push / pop / drain / clear,
//   item_word used by push only. results channel: one word per result with
//   out_word, out_valid, push_accepted, is_last and fill_count.
//   a command is held in a one-entry command register; items.ready is low
//   while a command is held, so the next command can be taken while the
//   previous result still sits in the output register.
// sequencing
//   push, clear, and pop/drain on an empty buffer: the result is loaded from
//   the idle state into the output register as soon as that is free.
//   pop: goes through the read state first for the registered ram read.
//   drain of N entries: N results on consecutive cycles after one ram read
//   while results.ready stays high; the read address is steered ahead so
//   the single ram read port delivers one entry per cycle.
// reset
//   arst_n clears head, tail, count, the command and output valid flags; ram
//   contents are left as they are and are only read after being written.
// stall
//   while results.ready is low the output register holds its word and the
//   sequencer waits; a drain resumes where it stopped, nothing is dropped.
// ----------------------------------------------------------------------------
module circular_fifo_with_drain_unit #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	cfwd_items_if.sink     items,
	cfwd_results_if.source results
);
	// command and status between sequencer and datapath
	cfwd_pkg::cfwd_ctl_t  ctl;
	cfwd_pkg::cfwd_stat_t stat;

	// sequencer
	cfwd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// pointers, store and output register
	cfwd_datapath #(.DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.ctl     (ctl),
		.stat    (stat)
	);

	// at most one pointer update per cycle
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.wr, ctl.pop, ctl.clr}))
		else $error("more than one pointer update in a cycle");

	// never overwrite a word still waiting in the output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> stat.out_free)
		else $error("output register loaded while occupied");

	// retiring a command frees the command register
	a_consume_frees: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.consume |=> !stat.cmd_valid)
		else $error("command register still busy after retire");

	// a data-carrying result is never a push acknowledge
	a_word_not_push: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.out_valid && results.push_accepted))
		else $error("result carries both a word and a push acknowledge");
endmodule
